// ===== rtl/core/dism_pkg.sv =====
// shared types and constants of the disc image sector map
// no dependencies; imported by the front, back and top level
`timescale 1ns / 1ps

package dism_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_TRACK  = 2'd1,
        MODE_CUE    = 2'd2,
        MODE_XLATE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_GAP    = 2'd1,
        STAT_BEYOND = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    // classified item handed from front to back
    typedef struct packed {
        mode_t       op;
        logic [31:0] sec;    // track start, cue start or sector to translate
        logic [31:0] num;    // track byte length or cue sector count
        logic [39:0] off;    // track image offset
        logic        form2;
    } cmd_t;

    localparam logic [11:0] SECTOR_BYTES   = 12'd2336;
    localparam logic [7:0]  PREGAP_SECTORS = 8'd150;
    localparam logic [3:0]  USER_SKIP      = 4'd8;
    localparam logic [11:0] USER_BYTES     = 12'd2048;

    // 2336 = 32 * 73: shift by 5, then reciprocal of 73 with one correction
    localparam int          SECTOR_SHIFT = 5;
    localparam logic [6:0]  SECTOR_ODD   = 7'd73;
    localparam logic [26:0] RECIP_73     = 27'd117670336;   // floor(2^33 / 73)
    localparam int          RECIP_SHIFT  = 33;

endpackage

// ===== rtl/core/dism_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dism_ram #(
    parameter int WIDTH  = 104,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/dism_front.sv =====
// front part: accepts items, classifies them and queues them for the back
// depends on dism_pkg
`timescale 1ns / 1ps

module dism_front
    import dism_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [31:0] entry_start_lsn,
    input  logic [31:0] entry_length_bytes,
    input  logic [39:0] entry_image_offset,
    input  logic [31:0] cue_lsn,
    input  logic [31:0] next_cue_lsn,
    input  logic [31:0] sector_lsn,
    input  logic        want_form2,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls;
    logic       do_push;
    logic       do_pop;

    // pick the operands that the back needs for each kind of item
    always_comb
    begin
        cls.op    = mode_t'(mode);
        cls.form2 = want_form2;
        cls.off   = entry_image_offset;
        unique case (mode_t'(mode))
            MODE_TRACK:
            begin
                cls.sec = entry_start_lsn;
                cls.num = entry_length_bytes;
            end
            MODE_CUE:
            begin
                cls.sec = cue_lsn;
                cls.num = next_cue_lsn - cue_lsn;
            end
            MODE_XLATE:
            begin
                cls.sec = sector_lsn;
                cls.num = '0;
            end
            default:
            begin
                cls.sec = '0;
                cls.num = '0;
            end
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/dism_back.sv =====
// back part: region table, add/translate sequencer and result register
// depends on dism_pkg and dism_ram
`timescale 1ns / 1ps

module dism_back
    import dism_pkg::*;
#(
    parameter int MAX_REGIONS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [39:0] image_byte_offset,
    output logic [3:0]  payload_skip,
    output logic [11:0] payload_length,
    output logic [31:0] covered_sectors,
    output logic [7:0]  region_total
);

    localparam int UW = $clog2(MAX_REGIONS + 1);
    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int RW = 32 + 32 + 40;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIV    = 8'b0000_0010,
        S_FIX    = 8'b0000_0100,
        S_STORE  = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_OFFMUL = 8'b0010_0000,
        S_OFFADD = 8'b0100_0000,
        S_RES    = 8'b1000_0000
    } state_t;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [39:0] off_reg, off_next;
    logic [53:0] prod_reg, prod_next;
    logic [31:0] rel_reg, rel_next;
    status_t     st_reg, st_next;
    logic [UW-1:0] used_reg, used_next;
    logic [31:0] cov_reg, cov_next;
    logic [UW-1:0] iss_reg, iss_next;
    logic [UW-1:0] chk_reg, chk_next;
    logic        rdv_reg, rdv_next;

    logic        out_valid_reg, out_valid_next;
    status_t     out_st_reg, out_st_next;
    logic [39:0] out_off_reg, out_off_next;
    logic [3:0]  out_skip_reg, out_skip_next;
    logic [11:0] out_len_reg, out_len_next;
    logic [31:0] out_cov_reg, out_cov_next;
    logic [7:0]  out_tot_reg, out_tot_next;

    logic          ram_we;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;
    logic [31:0]   rd_first;
    logic [31:0]   rd_cnt;
    logic [39:0]   rd_base;
    logic [31:0]   rel;
    logic          hit;
    logic          table_full;
    logic [26:0]   div_x;
    logic [20:0]   div_q;
    logic [26:0]   div_r;
    logic [31:0]   reg_end;
    logic [32:0]   cue_sum;
    logic [44:0]   cue_prod;

    dism_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (used_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (iss_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {first_reg, cnt_reg, off_reg};
    assign rd_first  = ram_rdata[RW-1 -: 32];
    assign rd_cnt    = ram_rdata[RW-33 -: 32];
    assign rd_base   = ram_rdata[39:0];
    assign rel       = cmd_reg.sec - rd_first;
    assign hit       = (rel < rd_cnt);
    assign table_full = (used_reg == UW'(MAX_REGIONS));

    // quotient estimate from the reciprocal is exact or one short
    assign div_x   = cmd_reg.num[31:SECTOR_SHIFT];
    assign div_q   = prod_reg[RECIP_SHIFT +: 21];
    assign div_r   = div_x - 27'(div_q) * 27'(SECTOR_ODD);
    assign reg_end = first_reg + cnt_reg;
    assign cue_sum = {1'b0, cmd.sec} + 33'(PREGAP_SECTORS);
    assign cue_prod = 45'(cue_sum) * 45'(SECTOR_BYTES);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        first_next     = first_reg;
        cnt_next       = cnt_reg;
        off_next       = off_reg;
        prod_next      = prod_reg;
        rel_next       = rel_reg;
        st_next        = st_reg;
        used_next      = used_reg;
        cov_next       = cov_reg;
        iss_next       = iss_reg;
        chk_next       = chk_reg;
        rdv_next       = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        out_st_next    = out_st_reg;
        out_off_next   = out_off_reg;
        out_skip_next  = out_skip_reg;
        out_len_next   = out_len_reg;
        out_cov_next   = out_cov_reg;
        out_tot_next   = out_tot_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    st_next  = STAT_OK;
                    off_next = '0;
                    iss_next = '0;
                    chk_next = '0;
                    unique case (cmd.op)
                        MODE_CLEAR:
                        begin
                            used_next  = '0;
                            cov_next   = '0;
                            state_next = S_RES;
                        end
                        MODE_TRACK:
                        begin
                            first_next = cmd.sec + 32'(32'(used_reg) * 32'(PREGAP_SECTORS));
                            prod_next  = 54'(cmd.num[31:SECTOR_SHIFT]) * 54'(RECIP_73);
                            if (table_full)
                            begin
                                st_next    = STAT_FULL;
                                state_next = S_RES;
                            end
                            else
                            begin
                                state_next = S_DIV;
                            end
                        end
                        MODE_CUE:
                        begin
                            first_next = cmd.sec;
                            cnt_next   = cmd.num;
                            if (table_full)
                            begin
                                st_next    = STAT_FULL;
                                state_next = S_RES;
                            end
                            else
                            begin
                                off_next   = cue_prod[39:0];
                                state_next = S_STORE;
                            end
                        end
                        default:
                        begin
                            if (cmd.sec >= cov_reg)
                            begin
                                st_next    = STAT_BEYOND;
                                state_next = S_RES;
                            end
                            else if (used_reg == '0)
                            begin
                                st_next    = STAT_GAP;
                                state_next = S_RES;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                state_next = S_FIX;
            end
            S_FIX:
            begin
                cnt_next   = 32'(div_q) + 32'(div_r >= 27'(SECTOR_ODD));
                off_next   = cmd_reg.off;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                ram_we    = 1'b1;
                used_next = used_reg + UW'(1);
                if (reg_end > cov_reg)
                begin
                    cov_next = reg_end;
                end
                state_next = S_RES;
            end
            S_SCAN:
            begin
                // issue one read a cycle, test the entry read the cycle before
                if (iss_reg < used_reg)
                begin
                    iss_next = iss_reg + UW'(1);
                    rdv_next = 1'b1;
                end
                if (rdv_reg)
                begin
                    chk_next = chk_reg + UW'(1);
                    if (hit)
                    begin
                        rel_next   = rel;
                        off_next   = rd_base;
                        rdv_next   = 1'b0;
                        state_next = S_OFFMUL;
                    end
                    else if (chk_reg + UW'(1) == used_reg)
                    begin
                        st_next    = STAT_GAP;
                        rdv_next   = 1'b0;
                        state_next = S_RES;
                    end
                end
            end
            S_OFFMUL:
            begin
                prod_next  = 54'(rel_reg) * 54'(SECTOR_BYTES);
                state_next = S_OFFADD;
            end
            S_OFFADD:
            begin
                off_next   = off_reg + prod_reg[39:0];
                state_next = S_RES;
            end
            default:
            begin
                // S_RES: hand the item's result to the output register
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = st_reg;
                    out_off_next   = off_reg;
                    out_cov_next   = cov_reg;
                    out_tot_next   = 8'(32'(used_reg));
                    if (cmd_reg.op == MODE_XLATE)
                    begin
                        out_skip_next = cmd_reg.form2 ? 4'd0 : USER_SKIP;
                        out_len_next  = cmd_reg.form2 ? SECTOR_BYTES : USER_BYTES;
                    end
                    else
                    begin
                        out_skip_next = '0;
                        out_len_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            cov_reg       <= '0;
            iss_reg       <= '0;
            chk_reg       <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cov_reg       <= cov_next;
            iss_reg       <= iss_next;
            chk_reg       <= chk_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        first_reg    <= first_next;
        cnt_reg      <= cnt_next;
        off_reg      <= off_next;
        prod_reg     <= prod_next;
        rel_reg      <= rel_next;
        st_reg       <= st_next;
        out_st_reg   <= out_st_next;
        out_off_reg  <= out_off_next;
        out_skip_reg <= out_skip_next;
        out_len_reg  <= out_len_next;
        out_cov_reg  <= out_cov_next;
        out_tot_reg  <= out_tot_next;
    end

    assign empty             = !out_valid_reg;
    assign status            = out_st_reg;
    assign image_byte_offset = out_off_reg;
    assign payload_skip      = out_skip_reg;
    assign payload_length    = out_len_reg;
    assign covered_sectors   = out_cov_reg;
    assign region_total      = out_tot_reg;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(MAX_REGIONS))
        else $error("region count above table depth");

    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !table_full)
        else $error("table write while full");

    a_result_from_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RES))
        else $error("result loaded outside result step");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (chk_reg <= iss_reg && iss_reg <= used_reg))
        else $error("scan pointers out of order");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg != S_IDLE))
        else $error("item taken from queue without leaving idle");
`endif

endmodule

// ===== rtl/core/disc_image_sector_map.sv =====
// top level of the disc image sector map
// depends on dism_pkg, dism_front, dism_back (and through it dism_ram)
`timescale 1ns / 1ps

// Sector region map for a 2336-byte-per-sector disc image. Items enter through
// a queue-style port (push/full) and results leave through one (empty/pop),
// exactly one result per item, in order. A two-entry queue in the front holds
// classified items so the producer can keep pushing while the back works and
// while a finished result waits to be popped. In the back, a clear, an add
// to a full table or an out-of-range translate goes straight to the result
// step; a cue pair first forms its image offset, and a track entry's byte
// length goes through a reciprocal multiply and one correction step; either
// then stores its region. A translate that is in range walks the region
// table through its single ram read port, one region per cycle in order,
// until the first matching region or the last region. The table is not
// cleared at reset: only entries below the current region count are ever
// read.

module disc_image_sector_map
    import dism_pkg::*;
#(
    parameter int MAX_REGIONS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    // item side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [31:0] entry_start_lsn,
    input  logic [31:0] entry_length_bytes,
    input  logic [39:0] entry_image_offset,
    input  logic [31:0] cue_lsn,
    input  logic [31:0] next_cue_lsn,
    input  logic [31:0] sector_lsn,
    input  logic        want_form2,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [39:0] image_byte_offset,
    output logic [3:0]  payload_skip,
    output logic [11:0] payload_length,
    output logic [31:0] covered_sectors,
    output logic [7:0]  region_total
);

    // classified item between front and back
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // front: decode mode, pick operands, queue the item
    dism_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .mode               (mode),
        .entry_start_lsn    (entry_start_lsn),
        .entry_length_bytes (entry_length_bytes),
        .entry_image_offset (entry_image_offset),
        .cue_lsn            (cue_lsn),
        .next_cue_lsn       (next_cue_lsn),
        .sector_lsn         (sector_lsn),
        .want_form2         (want_form2),
        .cmd_valid          (cmd_valid),
        .cmd                (cmd),
        .cmd_pop            (cmd_pop)
    );

    // back: region table, add and translate sequencing, result register
    dism_back #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cmd_pop           (cmd_pop),
        .empty             (empty),
        .pop               (pop),
        .status            (status),
        .image_byte_offset (image_byte_offset),
        .payload_skip      (payload_skip),
        .payload_length    (payload_length),
        .covered_sectors   (covered_sectors),
        .region_total      (region_total)
    );

endmodule
